FILE: rtl/core/qot_pkg.sv
// ----------------------------------------------------------------------------
// qot_pkg
// Types and constants shared by the offset transform pipeline.
// ----------------------------------------------------------------------------
package qot_pkg;

   localparam int QuatW   = 16;
   localparam int PosW    = 32;
   localparam int OffW    = 21;
   localparam int VecW    = 22;
   localparam int WidthW  = 19;
   localparam int HeightW = 18;
   localparam int ProdW   = 38;
   localparam int TW      = 26;
   localparam int RProdW  = 42;
   localparam int CsrIdxW = 2;

   localparam logic [CsrIdxW-1:0] REG_RIGHT   = 2'd0;
   localparam logic [CsrIdxW-1:0] REG_UP      = 2'd1;
   localparam logic [CsrIdxW-1:0] REG_FORWARD = 2'd2;
   localparam logic [CsrIdxW-1:0] REG_WIDTH   = 2'd3;

   localparam logic [WidthW-1:0] HEIGHT_MAX = 19'd262143;

   typedef logic signed [QuatW-1:0]  quat_type;
   typedef logic signed [PosW-1:0]   pos_type;
   typedef logic signed [OffW-1:0]   off_type;
   typedef logic signed [VecW-1:0]   vec_type;
   typedef logic signed [ProdW-1:0]  prod_type;
   typedef logic signed [TW-1:0]     tcomp_type;
   typedef logic signed [RProdW-1:0] rprod_type;
   typedef logic [WidthW-1:0]        width_type;
   typedef logic [HeightW-1:0]       height_type;

   typedef struct packed {
      quat_type x;
      quat_type y;
      quat_type z;
      quat_type w;
   } quat_set_type;

   typedef struct packed {
      vec_type x;
      vec_type y;
      vec_type z;
   } vec3_type;

   typedef struct packed {
      tcomp_type x;
      tcomp_type y;
      tcomp_type z;
   } tvec3_type;

   typedef struct packed {
      pos_type x;
      pos_type y;
      pos_type z;
   } pos3_type;

   typedef struct packed {
      logic load1;
      logic load2;
      logic load3;
      logic load4;
      logic load5;
   } pipe_ctl_type;

endpackage

FILE: rtl/core/qot_if.sv
// ----------------------------------------------------------------------------
// qot_if
// Request and response channels of the offset transform.
// ----------------------------------------------------------------------------
interface qot_req_if import qot_pkg::*; ();
   logic     valid;
   logic     ready;
   quat_type quat_x;
   quat_type quat_y;
   quat_type quat_z;
   quat_type quat_w;
   pos_type  origin_x;
   pos_type  origin_y;
   pos_type  origin_z;

   modport source (output valid, quat_x, quat_y, quat_z, quat_w,
                   origin_x, origin_y, origin_z, input ready);
   modport sink (input valid, quat_x, quat_y, quat_z, quat_w,
                 origin_x, origin_y, origin_z, output ready);
endinterface

interface qot_rsp_if import qot_pkg::*; ();
   logic       valid;
   logic       ready;
   pos_type    pos_x;
   pos_type    pos_y;
   pos_type    pos_z;
   width_type  width_out;
   height_type height_out;

   modport source (output valid, pos_x, pos_y, pos_z, width_out, height_out,
                   input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, width_out, height_out,
                 output ready);
endinterface

FILE: rtl/core/qot_tvec.sv
// ----------------------------------------------------------------------------
// qot_tvec
// Stages one and two: products of q and the offset, then t = 2*(q x v).
// ----------------------------------------------------------------------------
module qot_tvec import qot_pkg::*; (
   input  logic         clock,
   input  pipe_ctl_type ctl,
   input  quat_set_type quat,
   input  vec3_type     vec,
   output quat_set_type quat_out,
   output tvec3_type    t_out
);

   prod_type     p_yz_ff, p_zy_ff, p_zx_ff, p_xz_ff, p_xy_ff, p_yx_ff;
   quat_set_type q1_ff, q2_ff;
   tvec3_type    t_ff;
   logic signed [ProdW:0] d_x, d_y, d_z;

   always_ff @(posedge clock) begin
      if (ctl.load1) begin
         p_yz_ff <= ProdW'(quat.y) * ProdW'(vec.z);
         p_zy_ff <= ProdW'(quat.z) * ProdW'(vec.y);
         p_zx_ff <= ProdW'(quat.z) * ProdW'(vec.x);
         p_xz_ff <= ProdW'(quat.x) * ProdW'(vec.z);
         p_xy_ff <= ProdW'(quat.x) * ProdW'(vec.y);
         p_yx_ff <= ProdW'(quat.y) * ProdW'(vec.x);
         q1_ff   <= quat;
      end
   end

   assign d_x = (ProdW+1)'(p_yz_ff) - (ProdW+1)'(p_zy_ff);
   assign d_y = (ProdW+1)'(p_zx_ff) - (ProdW+1)'(p_xz_ff);
   assign d_z = (ProdW+1)'(p_xy_ff) - (ProdW+1)'(p_yx_ff);

   always_ff @(posedge clock) begin
      if (ctl.load2) begin
         t_ff.x <= d_x[ProdW:13];
         t_ff.y <= d_y[ProdW:13];
         t_ff.z <= d_z[ProdW:13];
         q2_ff  <= q1_ff;
      end
   end

   assign quat_out = q2_ff;
   assign t_out    = t_ff;

endmodule

FILE: rtl/core/qot_rotate.sv
// ----------------------------------------------------------------------------
// qot_rotate
// Stages three and four: w*t and q x t, then the rotated offset.
// ----------------------------------------------------------------------------
module qot_rotate import qot_pkg::*; (
   input  logic         clock,
   input  pipe_ctl_type ctl,
   input  quat_set_type quat,
   input  tvec3_type    t_in,
   input  vec3_type     vec,
   output pos3_type     rot_out
);

   rprod_type w_x_ff, w_y_ff, w_z_ff;
   rprod_type c_yz_ff, c_zy_ff, c_zx_ff, c_xz_ff, c_xy_ff, c_yx_ff;
   pos3_type  rot_ff;
   logic signed [RProdW:0]    d_x, d_y, d_z;
   logic signed [RProdW-15:0] ws_x, ws_y, ws_z;
   logic signed [RProdW-14:0] cs_x, cs_y, cs_z;

   always_ff @(posedge clock) begin
      if (ctl.load3) begin
         w_x_ff  <= RProdW'(quat.w) * RProdW'(t_in.x);
         w_y_ff  <= RProdW'(quat.w) * RProdW'(t_in.y);
         w_z_ff  <= RProdW'(quat.w) * RProdW'(t_in.z);
         c_yz_ff <= RProdW'(quat.y) * RProdW'(t_in.z);
         c_zy_ff <= RProdW'(quat.z) * RProdW'(t_in.y);
         c_zx_ff <= RProdW'(quat.z) * RProdW'(t_in.x);
         c_xz_ff <= RProdW'(quat.x) * RProdW'(t_in.z);
         c_xy_ff <= RProdW'(quat.x) * RProdW'(t_in.y);
         c_yx_ff <= RProdW'(quat.y) * RProdW'(t_in.x);
      end
   end

   assign d_x  = (RProdW+1)'(c_yz_ff) - (RProdW+1)'(c_zy_ff);
   assign d_y  = (RProdW+1)'(c_zx_ff) - (RProdW+1)'(c_xz_ff);
   assign d_z  = (RProdW+1)'(c_xy_ff) - (RProdW+1)'(c_yx_ff);
   assign ws_x = w_x_ff[RProdW-1:14];
   assign ws_y = w_y_ff[RProdW-1:14];
   assign ws_z = w_z_ff[RProdW-1:14];
   assign cs_x = d_x[RProdW:14];
   assign cs_y = d_y[RProdW:14];
   assign cs_z = d_z[RProdW:14];

   always_ff @(posedge clock) begin
      if (ctl.load4) begin
         rot_ff.x <= PosW'(vec.x) + PosW'(ws_x) + PosW'(cs_x);
         rot_ff.y <= PosW'(vec.y) + PosW'(ws_y) + PosW'(cs_y);
         rot_ff.z <= PosW'(vec.z) + PosW'(ws_z) + PosW'(cs_z);
      end
   end

   assign rot_out = rot_ff;

endmodule

FILE: rtl/core/qot_place.sv
// ----------------------------------------------------------------------------
// qot_place
// Stage five: saturating origin add, width echo and height, output register.
// ----------------------------------------------------------------------------
module qot_place import qot_pkg::*; (
   input  logic         clock,
   input  pipe_ctl_type ctl,
   input  pos3_type     rot,
   input  pos3_type     origin,
   input  width_type    width,
   output pos3_type     pos_out,
   output width_type    width_out,
   output height_type   height_out
);

   pos3_type   pos_ff;
   width_type  width_ff;
   height_type height_ff;
   logic signed [PosW:0] s_x, s_y, s_z;
   logic [WidthW+1:0]    w3;
   width_type            hq;

   function automatic pos_type sat(input logic signed [PosW:0] s);
      pos_type r;
      if (s[PosW] != s[PosW-1]) begin
         r = s[PosW] ? {1'b1, {(PosW-1){1'b0}}} : {1'b0, {(PosW-1){1'b1}}};
      end else begin
         r = s[PosW-1:0];
      end
      return r;
   endfunction

   assign s_x = (PosW+1)'(origin.x) + (PosW+1)'(rot.x);
   assign s_y = (PosW+1)'(origin.y) + (PosW+1)'(rot.y);
   assign s_z = (PosW+1)'(origin.z) + (PosW+1)'(rot.z);
   assign w3  = (WidthW+2)'(width) + {1'b0, width, 1'b0};
   assign hq  = w3[WidthW+1:2];

   always_ff @(posedge clock) begin
      if (ctl.load5) begin
         pos_ff.x  <= sat(s_x);
         pos_ff.y  <= sat(s_y);
         pos_ff.z  <= sat(s_z);
         width_ff  <= width;
         height_ff <= (hq > HEIGHT_MAX) ? HEIGHT_MAX[HeightW-1:0] : hq[HeightW-1:0];
      end
   end

   assign pos_out    = pos_ff;
   assign width_out  = width_ff;
   assign height_out = height_ff;

endmodule

FILE: rtl/core/quaternion_offset_transform.sv
// ----------------------------------------------------------------------------
// quaternion_offset_transform
// Rotates the configured local offset by a pose quaternion and adds the origin.
// ----------------------------------------------------------------------------
// Accepts one request per clock unless back-pressure from the response side
// holds the first stage, and returns one response per request, in order,
// through five register stages: q*v products, t, the w*t and q x t products,
// the rotated offset, and the saturating origin add with the output register.
// Stalls on the response side back up through the stages without loss. Write
// the offset and width registers only while no request is in flight.
module quaternion_offset_transform import qot_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   qot_req_if.sink            req_chan,
   qot_rsp_if.source          rsp_chan,
   input  logic               csr_we,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [OffW-1:0]    csr_wdata
);

   off_type      right_ff, up_ff, forward_ff;
   width_type    width_ff;
   logic [4:0]   valid_ff, valid_in;
   pipe_ctl_type ctl;
   vec3_type     vec;
   quat_set_type quat_in, quat_mid;
   tvec3_type    t_vec;
   pos3_type     rot, pos, origin_in;
   pos3_type     org1_ff, org2_ff, org3_ff, org4_ff;
   logic         en1, en2, en3, en4, en5;

   always_ff @(posedge clock) begin
      if (reset) begin
         right_ff   <= '0;
         up_ff      <= '0;
         forward_ff <= '0;
         width_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_RIGHT:   right_ff   <= csr_wdata;
            REG_UP:      up_ff      <= csr_wdata;
            REG_FORWARD: forward_ff <= csr_wdata;
            REG_WIDTH:   width_ff   <= csr_wdata[WidthW-1:0];
            default: ;
         endcase
      end
   end

   assign vec.x = VecW'(right_ff);
   assign vec.y = VecW'(up_ff);
   assign vec.z = -VecW'(forward_ff);

   // advance a stage when its register is empty or its contents move on
   assign en5 = !valid_ff[4] || rsp_chan.ready;
   assign en4 = !valid_ff[3] || en5;
   assign en3 = !valid_ff[2] || en4;
   assign en2 = !valid_ff[1] || en3;
   assign en1 = !valid_ff[0] || en2;

   assign ctl.load1 = en1;
   assign ctl.load2 = en2;
   assign ctl.load3 = en3;
   assign ctl.load4 = en4;
   assign ctl.load5 = en5;

   assign valid_in[0] = en1 ? req_chan.valid : valid_ff[0];
   assign valid_in[1] = en2 ? valid_ff[0]    : valid_ff[1];
   assign valid_in[2] = en3 ? valid_ff[1]    : valid_ff[2];
   assign valid_in[3] = en4 ? valid_ff[2]    : valid_ff[3];
   assign valid_in[4] = en5 ? valid_ff[3]    : valid_ff[4];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_chan.ready = en1;

   assign quat_in.x   = req_chan.quat_x;
   assign quat_in.y   = req_chan.quat_y;
   assign quat_in.z   = req_chan.quat_z;
   assign quat_in.w   = req_chan.quat_w;
   assign origin_in.x = req_chan.origin_x;
   assign origin_in.y = req_chan.origin_y;
   assign origin_in.z = req_chan.origin_z;

   always_ff @(posedge clock) begin
      if (en1) org1_ff <= origin_in;
      if (en2) org2_ff <= org1_ff;
      if (en3) org3_ff <= org2_ff;
      if (en4) org4_ff <= org3_ff;
   end

   qot_tvec u_tvec (
      .clock    (clock),
      .ctl      (ctl),
      .quat     (quat_in),
      .vec      (vec),
      .quat_out (quat_mid),
      .t_out    (t_vec)
   );

   qot_rotate u_rotate (
      .clock   (clock),
      .ctl     (ctl),
      .quat    (quat_mid),
      .t_in    (t_vec),
      .vec     (vec),
      .rot_out (rot)
   );

   qot_place u_place (
      .clock      (clock),
      .ctl        (ctl),
      .rot        (rot),
      .origin     (org4_ff),
      .width      (width_ff),
      .pos_out    (pos),
      .width_out  (rsp_chan.width_out),
      .height_out (rsp_chan.height_out)
   );

   assign rsp_chan.valid = valid_ff[4];
   assign rsp_chan.pos_x = pos.x;
   assign rsp_chan.pos_y = pos.y;
   assign rsp_chan.pos_z = pos.z;

endmodule
